@@ sv/ilir_pkg.sv @@
// Shared types and constants for the indexed list block.
// No dependencies; used by the sequencer, the top level and the checker.
package ilir_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int CMD_W = 3;
  localparam int IDX_W = 7;
  localparam int VAL_W = 32;
  localparam int CNT_W = 7;
  localparam int ST_W  = 2;

  localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] item_count;
    logic [VAL_W-1:0] read_value;
  } res_t;

endpackage

@@ sv/ilir_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ilir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/ilir_seq.sv @@
// Command sequencer: checks each command, then walks the entry RAM one entry per
// cycle for read, insert and remove shifts. Depends on ilir_pkg.
module ilir_seq #(
  parameter int CAPACITY = ilir_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ilir_pkg::CMD_W-1:0]          in_cmd,
  input  logic [ilir_pkg::IDX_W-1:0]          in_idx,
  input  logic [ilir_pkg::VAL_W-1:0]          in_val,
  output logic                                res_valid,
  input  logic                                res_ready,
  output ilir_pkg::res_t                      res,
  output logic                                ram_we,
  output logic [$clog2(CAPACITY)-1:0]         ram_waddr,
  output logic [ilir_pkg::VAL_W-1:0]          ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]         ram_raddr,
  input  logic [ilir_pkg::VAL_W-1:0]          ram_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + ilir_pkg::IDX_W;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                 state;
  logic [ilir_pkg::CMD_W-1:0] op;
  logic [AW-1:0]              tgt;
  logic [AW-1:0]              stop;
  logic [AW-1:0]              ptr;
  logic                       pend;
  logic [AW-1:0]              pend_addr;
  logic [ilir_pkg::VAL_W-1:0] val;
  logic [ilir_pkg::ST_W-1:0]  status;
  logic [ilir_pkg::VAL_W-1:0] rd_value;
  logic [CW-1:0]              count;

  logic [XW-1:0] idx_ext;
  logic [XW-1:0] cnt_ext;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_after;
  logic [XW-1:0] cnt_after_ext;
  logic          full;
  logic          idx_lt;
  logic          idx_gt;
  logic          accept;
  logic          fin_go;
  logic          st_ok;

  assign idx_ext = {{CW{1'b0}}, in_idx};
  assign cnt_ext = {{ilir_pkg::IDX_W{1'b0}}, count};
  assign cnt_m1  = count - CW'(1);
  assign full    = (count == CAP);
  assign idx_lt  = (idx_ext < cnt_ext);
  assign idx_gt  = (idx_ext > cnt_ext);

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_FIN);
  assign fin_go    = res_valid && res_ready;
  assign st_ok     = (status == ilir_pkg::ST_OK);

  always_comb begin
    cnt_after = count;
    if (st_ok && (op == ilir_pkg::CMD_INSERT || op == ilir_pkg::CMD_APPEND)) begin
      cnt_after = count + CW'(1);
    end else if (st_ok && op == ilir_pkg::CMD_REMOVE) begin
      cnt_after = cnt_m1;
    end
  end

  assign cnt_after_ext  = {{ilir_pkg::IDX_W{1'b0}}, cnt_after};
  assign res.read_value = rd_value;
  assign res.item_count = cnt_after_ext[ilir_pkg::CNT_W-1:0];
  assign res.status     = status;

  // One write port: final store on completion, else the shift write-back of
  // the entry read in the previous cycle.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tgt;
    ram_wdata = val;
    ram_raddr = ptr;
    if (fin_go && st_ok && (op == ilir_pkg::CMD_WRITE || op == ilir_pkg::CMD_APPEND ||
                            op == ilir_pkg::CMD_INSERT)) begin
      ram_we = 1'b1;
    end else if (pend && op == ilir_pkg::CMD_INSERT) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr + AW'(1);
      ram_wdata = ram_rdata;
    end else if (pend && op == ilir_pkg::CMD_REMOVE && pend_addr != tgt) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr - AW'(1);
      ram_wdata = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      // read and remove return the entry at the index
      if (pend && op != ilir_pkg::CMD_INSERT && pend_addr == tgt) begin
        rd_value <= ram_rdata;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op       <= in_cmd;
            val      <= in_val;
            rd_value <= '0;
            pend     <= 1'b0;
            tgt      <= idx_ext[AW-1:0];
            status   <= ilir_pkg::ST_OK;
            state    <= S_FIN;
            case (in_cmd)
              ilir_pkg::CMD_READ: begin
                if (idx_lt) begin
                  ptr   <= idx_ext[AW-1:0];
                  stop  <= idx_ext[AW-1:0];
                  state <= S_SCAN;
                end else begin
                  status <= ilir_pkg::ST_RANGE;
                end
              end
              ilir_pkg::CMD_WRITE: begin
                if (!idx_lt) begin
                  status <= ilir_pkg::ST_RANGE;
                end
              end
              ilir_pkg::CMD_APPEND: begin
                tgt <= count[AW-1:0];
                if (full) begin
                  status <= ilir_pkg::ST_FULL;
                end
              end
              ilir_pkg::CMD_INSERT: begin
                if (idx_gt) begin
                  status <= ilir_pkg::ST_RANGE;
                end else if (full) begin
                  status <= ilir_pkg::ST_FULL;
                end else if (idx_lt) begin
                  // shift down from the top entry to the index
                  ptr   <= cnt_m1[AW-1:0];
                  stop  <= idx_ext[AW-1:0];
                  state <= S_SCAN;
                end
              end
              ilir_pkg::CMD_REMOVE: begin
                if (idx_lt) begin
                  ptr   <= idx_ext[AW-1:0];
                  stop  <= cnt_m1[AW-1:0];
                  state <= S_SCAN;
                end else begin
                  status <= ilir_pkg::ST_RANGE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          pend      <= 1'b1;
          pend_addr <= ptr;
          if (ptr == stop) begin
            state <= S_TAIL;
          end else if (op == ilir_pkg::CMD_INSERT) begin
            ptr <= ptr - AW'(1);
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        S_TAIL: begin
          pend  <= 1'b0;
          state <= S_FIN;
        end
        S_FIN: begin
          if (res_ready) begin
            count <= cnt_after;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/indexed_list_insert_remove.sv @@
// Indexed list of signed 32-bit entries held in one synchronous RAM. Write,
// append, insert at the end and failed commands need no scan; read scans the
// entry at the index; remove and insert below the end shift every entry from
// the index to the end through the RAM's single read and write port. A finished
// result sits in an output register, so the next command is taken while it
// waits. Depends on ilir_pkg, ilir_seq and ilir_ram.
module indexed_list_insert_remove #(
  parameter int CAPACITY = ilir_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] command, [9:3] index, [41:10] item_value, [47:42] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] read_value, [38:32] item_count, [40:39] status, [47:41] zero
  output logic [47:0] m_axis_tdata
);

  localparam int AW = $clog2(CAPACITY);

  logic                       res_valid;
  logic                       res_ready;
  ilir_pkg::res_t             res;
  ilir_pkg::res_t             out_res;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [ilir_pkg::VAL_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [ilir_pkg::VAL_W-1:0] ram_rdata;

  ilir_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (s_axis_tdata[2:0]),
    .in_idx    (s_axis_tdata[9:3]),
    .in_val    (s_axis_tdata[41:10]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ilir_ram #(.WIDTH(ilir_pkg::VAL_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {7'b0, out_res};

endmodule

@@ sv/ilir_checker.sv @@
// Port-level checks for indexed_list_insert_remove, attached by bind.
// Depends on ilir_pkg.
module ilir_checker #(
  parameter int CAPACITY = ilir_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // a result waiting for the sink must hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[40:39] != ilir_pkg::ST_BAD)
    else $error("undefined status code");

  // failed commands return zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[40:39] != ilir_pkg::ST_OK |-> m_axis_tdata[31:0] == '0)
    else $error("failed command returned data");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (CAPACITY > 127) || (m_axis_tdata[38:32] <= 7'(CAPACITY)))
    else $error("count above capacity");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result presented after reset");

endmodule

bind indexed_list_insert_remove ilir_checker #(.CAPACITY(CAPACITY)) u_ilir_checker (.*);
